// ----- rtl/core/flws_pkg.sv -----
package flws_pkg;

    localparam int DEF_MAX_LIGHTS = 256;

    localparam int ID_W   = 16;
    localparam int FLUX_W = 32;
    localparam int FRAC_W = 32;
    localparam int TOT_W  = 40;

    localparam logic [FRAC_W-1:0] FRAC_MAX = '1;
    localparam logic [TOT_W-1:0]  TOT_MAX  = '1;

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_NO_LIGHTS = 2'd1,
        ST_FULL      = 2'd2,
        ST_DISCARDED = 2'd3
    } status_t;

    // One queued item as handed from the front end to the back end.
    typedef struct packed
    {
        op_t               op;
        logic [ID_W-1:0]   light_id;
        logic [FLUX_W-1:0] flux;
        logic              is_virtual;
        logic [FRAC_W-1:0] random_fraction;
    } item_t;

endpackage

// ----- rtl/core/flux_weighted_light_sampler_core.sv -----
// Flux-weighted light sampler.
// The input channel (in_valid / in_stall) carries one item per handshake: op selects
// a load (append light_id with weight flux, unless it is virtual and virtual
// lights are excluded or the table is full) or a sample (draw a light with probability
// proportional to its weight, using random_fraction as the uniform variable).
// Every item produces exactly one result item on the output channel
// (out_valid / out_stall): status, chosen_id, remapped_fraction, probability.
// The configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
// include_virtual bit; cfg_ready is always high and writes are expected only
// while the block is idle.
// A two-entry queue sits in front of the execution engine, so up to two items
// are taken while the engine is busy. With the engine idle, a load or a sample
// that finds no lights goes from the queue through the idle and done states to
// the output register. A sample walks the entries in order, each through a read
// and a compare state, then runs two 64-step bit-per-cycle divisions; a saturated
// remapped fraction skips the first and a chosen zero weight skips both.
// The engine works on one item at a time, which sets the throughput.
// Reset empties the table, clears the total, the queue and the output, and
// sets include_virtual to 0. A stalled result is held in the output register
// unchanged; the engine finishes its next item and waits until it can hand off.
module flux_weighted_light_sampler_core
#(
    parameter int MAX_LIGHTS = flws_pkg::DEF_MAX_LIGHTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [15:0] light_id,
    input  logic [31:0] flux,
    input  logic        is_virtual,
    input  logic [31:0] random_fraction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] chosen_id,
    output logic [31:0] remapped_fraction,
    output logic [31:0] probability,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import flws_pkg::*;

    logic  incl_virt_reg, incl_virt_next;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    // The register is a single bit, so a write can always be taken.
    assign cfg_ready      = 1'b1;
    assign incl_virt_next = (cfg_valid && cfg_ready) ? cfg_data : incl_virt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            incl_virt_reg <= 1'b0;
        end
        else
        begin
            incl_virt_reg <= incl_virt_next;
        end
    end

    // Front end: takes items and queues them for the engine.
    flws_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .light_id        (light_id),
        .flux            (flux),
        .is_virtual      (is_virtual),
        .random_fraction (random_fraction),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_item          (q_item)
    );

    // Back end: table memory, cumulative walk, divider and output register.
    flws_back
    #(
        .MAX_LIGHTS (MAX_LIGHTS)
    )
    u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .include_virtual   (incl_virt_reg),
        .q_valid           (q_valid),
        .q_pop             (q_pop),
        .q_item            (q_item),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .chosen_id         (chosen_id),
        .remapped_fraction (remapped_fraction),
        .probability       (probability)
    );

endmodule

// ----- rtl/core/flws_front.sv -----
module flws_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    op,
    input  logic [15:0]             light_id,
    input  logic [31:0]             flux,
    input  logic                    is_virtual,
    input  logic [31:0]             random_fraction,
    output logic                    q_valid,
    input  logic                    q_pop,
    output flws_pkg::item_t         q_item
);
    import flws_pkg::*;

    // Two-entry queue that decouples intake from the back end.
    item_t       q_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    logic        pop;
    item_t       in_item;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb
    begin
        in_item.op              = op_t'(op);
        in_item.light_id        = light_id;
        in_item.flux            = flux;
        in_item.is_virtual      = is_virtual;
        in_item.random_fraction = random_fraction;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/flws_back.sv -----
module flws_back
#(
    parameter int MAX_LIGHTS = flws_pkg::DEF_MAX_LIGHTS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    include_virtual,
    input  logic                    q_valid,
    output logic                    q_pop,
    input  flws_pkg::item_t         q_item,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic [15:0]             chosen_id,
    output logic [31:0]             remapped_fraction,
    output logic [31:0]             probability
);
    import flws_pkg::*;

    localparam int AW    = $clog2(MAX_LIGHTS);
    localparam int CNT_W = $clog2(MAX_LIGHTS + 1);
    localparam int SUM_W = TOT_W + 1 + AW;
    localparam int NUM_W = 2 * FRAC_W;
    localparam int STP_W = $clog2(NUM_W);

    typedef enum logic [8:0]
    {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_TGT  = 9'b000000100,
        S_RD   = 9'b000001000,
        S_CMP  = 9'b000010000,
        S_CHK  = 9'b000100000,
        S_DIV1 = 9'b001000000,
        S_DIV2 = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    logic [FLUX_W-1:0] weight_mem [MAX_LIGHTS];
    logic [ID_W-1:0]   id_mem     [MAX_LIGHTS];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [FRAC_W-1:0]  u_reg, u_next;
    logic [63:0]        plo_reg, plo_next;
    logic [TOT_W-1:0]   phi_reg, phi_next;
    logic [TOT_W-1:0]   tint_reg, tint_next;
    logic [FRAC_W-1:0]  tfrac_reg, tfrac_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [FLUX_W-1:0]  w_reg, w_next;
    logic [ID_W-1:0]    pid_reg, pid_next;
    logic [SUM_W-1:0]   prefix_reg, prefix_next;
    logic [TOT_W:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [TOT_W-1:0]   dvs_reg, dvs_next;
    logic [STP_W-1:0]   step_reg, step_next;
    logic [1:0]         rs_reg, rs_next;
    logic [ID_W-1:0]    rid_reg, rid_next;
    logic [FRAC_W-1:0]  rmap_reg, rmap_next;
    logic [FRAC_W-1:0]  rprob_reg, rprob_next;
    logic               ov_reg, ov_next;
    logic [1:0]         os_reg, os_next;
    logic [ID_W-1:0]    oid_reg, oid_next;
    logic [FRAC_W-1:0]  omap_reg, omap_next;
    logic [FRAC_W-1:0]  oprob_reg, oprob_next;

    logic [FLUX_W-1:0]  rd_w_reg;
    logic [ID_W-1:0]    rd_id_reg;
    logic               we;
    logic [TOT_W:0]     tot_sum;
    logic [SUM_W-1:0]   sum_cmp;
    logic [SUM_W-1:0]   tint_ext;
    logic [SUM_W-1:0]   diff;
    logic [FRAC_W-1:0]  diff_frac;
    logic               hit;
    logic               last;
    logic [TOT_W:0]     r2;
    logic               ge;
    logic [NUM_W-1:0]   quo_fin;
    logic               out_free;

    assign tot_sum  = {1'b0, total_reg} + (TOT_W + 1)'(q_item.flux);
    assign sum_cmp  = sum_reg + SUM_W'(rd_w_reg);
    assign tint_ext = SUM_W'(tint_reg);
    assign last     = (CNT_W'(idx_reg) == count_reg - 1'b1);
    assign hit      = (sum_cmp > tint_ext) || ((sum_cmp == tint_ext) && (tfrac_reg == '0))
                      || last;
    assign r2       = {rem_reg[TOT_W-1:0], num_reg[NUM_W-1]};
    assign ge       = (r2 >= {1'b0, dvs_reg});
    assign quo_fin  = {quo_reg[NUM_W-2:0], ge};
    assign out_free = !ov_reg || !out_stall;

    always_comb
    begin
        if (tint_ext >= prefix_reg)
        begin
            diff      = tint_ext - prefix_reg;
            diff_frac = tfrac_reg;
        end
        else
        begin
            diff      = '0;
            diff_frac = '0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        u_next      = u_reg;
        plo_next    = plo_reg;
        phi_next    = phi_reg;
        tint_next   = tint_reg;
        tfrac_next  = tfrac_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        w_next      = w_reg;
        pid_next    = pid_reg;
        prefix_next = prefix_reg;
        rem_next    = rem_reg;
        num_next    = num_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        step_next   = step_reg;
        rs_next     = rs_reg;
        rid_next    = rid_reg;
        rmap_next   = rmap_reg;
        rprob_next  = rprob_reg;
        ov_next     = ov_reg && out_stall;
        os_next     = os_reg;
        oid_next    = oid_reg;
        omap_next   = omap_reg;
        oprob_next  = oprob_reg;
        q_pop       = 1'b0;
        we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    rid_next   = '0;
                    rmap_next  = '0;
                    rprob_next = '0;
                    state_next = S_DONE;
                    if (q_item.op == OP_LOAD)
                    begin
                        if (q_item.is_virtual && !include_virtual)
                        begin
                            rs_next = ST_DISCARDED;
                        end
                        else if (count_reg >= CNT_W'(MAX_LIGHTS))
                        begin
                            rs_next = ST_FULL;
                        end
                        else
                        begin
                            we         = 1'b1;
                            count_next = count_reg + 1'b1;
                            total_next = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
                            rs_next    = ST_OK;
                        end
                    end
                    else if (count_reg == '0 || total_reg == '0)
                    begin
                        rs_next = ST_NO_LIGHTS;
                    end
                    else
                    begin
                        u_next     = q_item.random_fraction;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                plo_next   = u_reg * total_reg[31:0];
                phi_next   = TOT_W'(u_reg) * TOT_W'(total_reg[TOT_W-1:32]);
                state_next = S_TGT;
            end
            S_TGT:
            begin
                tint_next  = phi_reg + TOT_W'(plo_reg[63:32]);
                tfrac_next = plo_reg[31:0];
                idx_next   = '0;
                sum_next   = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (hit)
                begin
                    w_next      = rd_w_reg;
                    pid_next    = rd_id_reg;
                    prefix_next = sum_cmp - SUM_W'(rd_w_reg);
                    state_next  = S_CHK;
                end
                else
                begin
                    sum_next   = sum_cmp;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_CHK:
            begin
                rem_next  = '0;
                quo_next  = '0;
                step_next = '0;
                if (w_reg == '0)
                begin
                    rs_next    = ST_NO_LIGHTS;
                    state_next = S_DONE;
                end
                else if (diff >= SUM_W'(w_reg))
                begin
                    rmap_next  = FRAC_MAX;
                    num_next   = {w_reg, {FRAC_W{1'b0}}};
                    dvs_next   = total_reg;
                    state_next = S_DIV2;
                end
                else
                begin
                    num_next   = {diff[FRAC_W-1:0], diff_frac};
                    dvs_next   = TOT_W'(w_reg);
                    state_next = S_DIV1;
                end
            end
            S_DIV1, S_DIV2:
            begin
                rem_next  = ge ? (r2 - {1'b0, dvs_reg}) : r2;
                quo_next  = quo_fin;
                num_next  = {num_reg[NUM_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STP_W'(NUM_W - 1))
                begin
                    step_next = '0;
                    rem_next  = '0;
                    quo_next  = '0;
                    if (state_reg == S_DIV1)
                    begin
                        rmap_next  = quo_fin[FRAC_W-1:0];
                        num_next   = {w_reg, {FRAC_W{1'b0}}};
                        dvs_next   = total_reg;
                        state_next = S_DIV2;
                    end
                    else
                    begin
                        rprob_next = (quo_fin[NUM_W-1:FRAC_W] != '0) ? FRAC_MAX
                                     : quo_fin[FRAC_W-1:0];
                        rs_next    = ST_OK;
                        rid_next   = pid_reg;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    os_next    = rs_reg;
                    oid_next   = (rs_reg == ST_OK) ? rid_reg : '0;
                    omap_next  = (rs_reg == ST_OK) ? rmap_reg : '0;
                    oprob_next = (rs_reg == ST_OK) ? rprob_reg : '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            weight_mem[count_reg[AW-1:0]] <= q_item.flux;
            id_mem[count_reg[AW-1:0]]     <= q_item.light_id;
        end
        rd_w_reg  <= weight_mem[idx_reg];
        rd_id_reg <= id_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        plo_reg    <= plo_next;
        phi_reg    <= phi_next;
        tint_reg   <= tint_next;
        tfrac_reg  <= tfrac_next;
        idx_reg    <= idx_next;
        sum_reg    <= sum_next;
        w_reg      <= w_next;
        pid_reg    <= pid_next;
        prefix_reg <= prefix_next;
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        step_reg   <= step_next;
        rs_reg     <= rs_next;
        rid_reg    <= rid_next;
        rmap_reg   <= rmap_next;
        rprob_reg  <= rprob_next;
        os_reg     <= os_next;
        oid_reg    <= oid_next;
        omap_reg   <= omap_next;
        oprob_reg  <= oprob_next;
    end

    assign out_valid         = ov_reg;
    assign status            = os_reg;
    assign chosen_id         = oid_reg;
    assign remapped_fraction = omap_reg;
    assign probability       = oprob_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LIGHTS))
        else $error("entry count exceeds table size");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("walk index beyond loaded entries");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV1 || state_reg == S_DIV2) |-> (dvs_reg != '0))
        else $error("divider running with zero divisor");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && state_reg == S_IDLE))
        else $error("queue popped outside idle");

endmodule
